>>> rtl/hcbp_pkg.sv
// package with shared types and constants for the huffman code bit packer
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  localparam int SYM_W      = 8;
  localparam int CODE_IN_W  = 32;
  localparam int LEN_IN_W   = 6;
  localparam logic [7:0] END_MARKER = 8'hAA;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_FULL    = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_COUNT   = 2'd2,
    KIND_MARKER  = 2'd3
  } kind_t;

  typedef struct packed {
    action_t               action;
    logic [SYM_W-1:0]      symbol;
    logic [CODE_IN_W-1:0]  code_bits;
    logic [LEN_IN_W-1:0]   code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      byte_kind;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    action_t               action;
    logic [CODE_IN_W-1:0]  code;
    logic [LEN_IN_W-1:0]   len;
  } lookup_t;

endpackage

`default_nettype wire

>>> rtl/hcbp_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/hcbp_table.sv
// code table with entry valid bits and the lookup stage register
`timescale 1ns / 1ps
`default_nettype none

module hcbp_table #(
  parameter int TABLE_ENTRIES = 128,
  parameter int MAX_CODE_LEN  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hcbp_pkg::in_item_t req,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire logic              advance,
  output logic                   look_valid,
  output hcbp_pkg::lookup_t      look
);

  import hcbp_pkg::*;

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CODE_W = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int RAM_W  = LEN_W + CODE_W;

  logic                     accept;
  logic [IDX_W-1:0]         idx;
  logic                     in_range;
  logic                     wr_en;
  logic [LEN_W-1:0]         len_sat;
  logic [RAM_W-1:0]         wr_data;
  logic [RAM_W-1:0]         rd_data;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic                     hit;
  action_t                  action;

  assign req_ready = !look_valid || advance;
  assign accept    = req_valid && req_ready;
  assign idx       = req.symbol[IDX_W-1:0];
  assign in_range  = {1'b0, req.symbol} < (SYM_W + 1)'(TABLE_ENTRIES);
  assign wr_en     = accept && (req.action == ACT_LOAD) && in_range;
  assign len_sat   = (req.code_length > LEN_IN_W'(MAX_CODE_LEN)) ?
                     LEN_W'(MAX_CODE_LEN) : LEN_W'(req.code_length);
  assign wr_data   = {len_sat, req.code_bits[CODE_W-1:0]};

  hcbp_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      look_valid <= 1'b0;
    end else if (accept) begin
      look_valid <= 1'b1;
    end else if (advance) begin
      look_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action <= req.action;
      hit    <= in_range && entry_valid[idx];
    end
  end

  always_comb begin
    look.action = action;
    look.code   = hit ? CODE_IN_W'(rd_data[CODE_W-1:0]) : '0;
    look.len    = hit ? LEN_IN_W'(rd_data[RAM_W-1 -: LEN_W]) : '0;
  end

endmodule

`default_nettype wire

>>> rtl/hcbp_packer.sv
// bit accumulator, byte packing and output byte buffer
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              look_valid,
  input  wire hcbp_pkg::lookup_t look,
  output logic                   advance,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output hcbp_pkg::out_item_t    result
);

  import hcbp_pkg::*;

  localparam int ACC_BYTES = (MAX_CODE_LEN + 14) / 8;
  localparam int ACC_W     = 8 * ACC_BYTES;
  localparam int OB_DEPTH  = (ACC_BYTES > 3) ? ACC_BYTES : 3;
  localparam int CNT_W     = $clog2(OB_DEPTH + 1);
  localparam int TOT_W     = $clog2(MAX_CODE_LEN + 8);
  localparam int SH_W      = $clog2(ACC_W + 1);

  logic [7:0]       pend_byte;
  logic [2:0]       pend_cnt;
  logic [7:0]       pend_byte_next;
  logic [2:0]       pend_cnt_next;
  logic [7:0]       ob_byte [OB_DEPTH];
  kind_t            ob_kind [OB_DEPTH];
  logic [CNT_W-1:0] ob_cnt;
  logic [7:0]       nb_byte [OB_DEPTH];
  kind_t            nb_kind [OB_DEPTH];
  logic [CNT_W-1:0] n_new;
  logic [ACC_W-1:0] code_m;
  logic [SH_W-1:0]  shamt;
  logic [ACC_W-1:0] word;
  logic [ACC_W-1:0] word_rest;
  logic [TOT_W-1:0] total;
  logic             take;
  logic             ob_free;

  assign code_m    = ACC_W'(look.code) & ~({ACC_W{1'b1}} << look.len);
  assign shamt     = SH_W'(ACC_W) - SH_W'(pend_cnt) - SH_W'(look.len);
  assign word      = (ACC_W'(pend_byte) << (ACC_W - 8)) | (code_m << shamt);
  assign total     = TOT_W'(pend_cnt) + TOT_W'(look.len);
  assign word_rest = word << {total[TOT_W-1:3], 3'b000};

  always_comb begin
    for (int j = 0; j < OB_DEPTH; j++) begin
      nb_byte[j] = '0;
      nb_kind[j] = KIND_FULL;
    end
    n_new          = '0;
    pend_byte_next = pend_byte;
    pend_cnt_next  = pend_cnt;
    unique case (look.action)
      ACT_ENCODE: begin
        for (int j = 0; j < ACC_BYTES; j++) begin
          nb_byte[j] = word[ACC_W-1-8*j -: 8];
        end
        n_new          = CNT_W'(total[TOT_W-1:3]);
        pend_byte_next = word_rest[ACC_W-1 -: 8];
        pend_cnt_next  = total[2:0];
      end
      ACT_FLUSH: begin
        if (pend_cnt != '0) begin
          nb_byte[0]     = pend_byte;
          nb_kind[0]     = KIND_PARTIAL;
          nb_byte[1]     = {5'b00000, pend_cnt};
          nb_kind[1]     = KIND_COUNT;
          nb_byte[2]     = END_MARKER;
          nb_kind[2]     = KIND_MARKER;
          n_new          = CNT_W'(3);
          pend_byte_next = '0;
          pend_cnt_next  = '0;
        end
      end
      ACT_LOAD, ACT_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign result_valid = (ob_cnt != '0);
  assign take         = result_valid && result_ready;
  assign ob_free      = (ob_cnt == '0) || ((ob_cnt == CNT_W'(1)) && take);
  assign advance      = look_valid && ((n_new == '0) || ob_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_byte <= '0;
      pend_cnt  <= '0;
      ob_cnt    <= '0;
    end else begin
      if (advance) begin
        pend_byte <= pend_byte_next;
        pend_cnt  <= pend_cnt_next;
      end
      if (advance && (n_new != '0)) begin
        ob_cnt <= n_new;
      end else if (take) begin
        ob_cnt <= ob_cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (n_new != '0)) begin
      for (int j = 0; j < OB_DEPTH; j++) begin
        ob_byte[j] <= nb_byte[j];
        ob_kind[j] <= nb_kind[j];
      end
    end else if (take) begin
      for (int j = 0; j < OB_DEPTH - 1; j++) begin
        ob_byte[j] <= ob_byte[j+1];
        ob_kind[j] <= ob_kind[j+1];
      end
    end
  end

  always_comb begin
    result.out_byte    = ob_byte[0];
    result.byte_kind   = ob_kind[0];
    result.last_of_run = (ob_cnt == CNT_W'(1));
  end

endmodule

`default_nettype wire

>>> rtl/huffman_code_bit_packer_top.sv
// top level of the huffman code bit packer
//
// input channel item: load a table entry, encode a symbol, or flush the stream
// result channel: packed bytes, each tagged full, partial, bit count or marker,
// with last_of_run set on the final byte caused by one request
// the accepting edge loads the code table ram read and the lookup register, and
// the bytes then pass from the lookup register into the result buffer register
// once that buffer is free, and the first byte is offered from there
// the result buffer sends one byte per cycle while result_ready is high: an
// encode gives k full bytes, and a flush with pending bits gives three bytes
// (partial, bit count, marker), all through the single result port
// loads and requests giving no bytes pass without waiting on the buffer
// reset clears the accumulator, the buffer and every table entry valid bit, so
// all codes read as empty until loaded; no clearing pass is needed
// when the receiver stalls, the buffered bytes hold, one more request is held
// in the lookup stage and ready drops
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer_top #(
  parameter int TABLE_ENTRIES = 128,
  parameter int MAX_CODE_LEN  = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire hcbp_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output hcbp_pkg::out_item_t      result
);

  import hcbp_pkg::*;

  logic    look_valid;
  lookup_t look;
  logic    advance;

  hcbp_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_LEN  (MAX_CODE_LEN)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .req        (item),
    .req_valid  (item_valid),
    .req_ready  (item_ready),
    .advance    (advance),
    .look_valid (look_valid),
    .look       (look)
  );

  hcbp_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk          (clk),
    .rst          (rst),
    .look_valid   (look_valid),
    .look         (look),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
